### rtl/core/rc_pkg.sv
// ----------------------------------------------------------------------------
// rc_pkg
// Shared types, constants and digit mapping functions for the radix converter.
// ----------------------------------------------------------------------------
package rc_pkg;

	localparam int ACC_BITS_DEF       = 32;
	localparam int MAX_OUT_DIGITS_DEF = 32;

	localparam int BASE_W  = 6;
	localparam int CHAR_W  = 8;
	localparam int OCHAR_W = 7;
	localparam int DIGIT_W = 6;
	localparam int REG_W   = 2;

	localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
	localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

	localparam logic [CHAR_W-1:0] CH_0   = 8'd48;  // '0'
	localparam logic [CHAR_W-1:0] CH_9   = 8'd57;  // '9'
	localparam logic [CHAR_W-1:0] CH_UA  = 8'd65;  // 'A'
	localparam logic [CHAR_W-1:0] CH_UZ  = 8'd90;  // 'Z'
	localparam logic [CHAR_W-1:0] CH_LA  = 8'd97;  // 'a'
	localparam logic [CHAR_W-1:0] CH_LZ  = 8'd122; // 'z'
	localparam logic [CHAR_W-1:0] TEN    = 8'd10;

	localparam logic [OCHAR_W-1:0] OCH_0  = 7'd48;
	localparam logic [OCHAR_W-1:0] OCH_9  = 7'd57;
	localparam logic [OCHAR_W-1:0] OCH_UA = 7'd65;
	localparam logic [OCHAR_W-1:0] OCH_UZ = 7'd90;

	typedef enum logic [REG_W-1:0] {
		REG_SOURCE_BASE = 2'd0,
		REG_TARGET_BASE = 2'd1
	} reg_idx_t;

	// Datapath actions issued by the sequencer for the current step
	typedef struct packed {
		logic capture;    // take the input character
		logic mac;        // acc = acc * source_base + digit
		logic div_init;   // load dividend from acc, clear acc and digit count
		logic div_start;  // clear remainder, arm bit counter
		logic div_step;   // one restoring division step
		logic store;      // write remainder to the digit store
		logic emit_rd;    // read the next digit from the store
		logic emit_ld;    // load the output register
	} act_t;

	// Datapath status fed back to the sequencer's jump conditions
	typedef struct packed {
		logic last;
		logic div_last;
		logic more;
		logic out_free;
		logic count_nz;
	} stat_t;

	function automatic logic [DIGIT_W-1:0] char_value(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] v;
		v = '0;
		if (c >= CH_LA && c <= CH_LZ) begin
			v = c - CH_LA + TEN;
		end else if (c >= CH_UA && c <= CH_UZ) begin
			v = c - CH_UA + TEN;
		end else if (c >= CH_0 && c <= CH_9) begin
			v = c - CH_0;
		end
		return v[DIGIT_W-1:0];
	endfunction

	function automatic logic [OCHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
		logic [OCHAR_W-1:0] r;
		if (d < DIGIT_W'(10)) begin
			r = OCH_0 + OCHAR_W'(d);
		end else begin
			r = OCH_UA + OCHAR_W'(d) - OCHAR_W'(10);
		end
		return r;
	endfunction

endpackage

### rtl/core/rc_ram.sv
// ----------------------------------------------------------------------------
// rc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rc_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/rc_seq.sv
// ----------------------------------------------------------------------------
// rc_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module rc_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  rc_pkg::stat_t stat,
	output rc_pkg::act_t  act
);
	import rc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE    = 3'd0,
		S_MAC     = 3'd1,
		S_DIVINIT = 3'd2,
		S_DIVSTRT = 3'd3,
		S_DIVSTEP = 3'd4,
		S_STORE   = 3'd5,
		S_EMIT_RD = 3'd6,
		S_EMIT_LD = 3'd7
	} step_t;

	typedef enum logic [2:0] {
		C_ALWAYS   = 3'd0,
		C_IN_VALID = 3'd1,
		C_LAST     = 3'd2,
		C_DIV_LAST = 3'd3,
		C_MORE     = 3'd4,
		C_OUT_FREE = 3'd5,
		C_COUNT_NZ = 3'd6
	} cond_t;

	typedef struct packed {
		step_t next_step;  // taken when the condition is false
		step_t jump_step;  // taken when the condition is true
		cond_t cond;
		logic  gated;      // actions fire only when the condition holds
		act_t  act;
	} uword_t;

	function automatic uword_t ucode(input step_t s);
		uword_t w;
		w = '{next_step: S_IDLE, jump_step: S_IDLE, cond: C_ALWAYS, gated: 1'b0,
			act: '0};
		case (s)
			S_IDLE: begin
				w.next_step = S_IDLE;    w.jump_step = S_MAC;
				w.cond = C_IN_VALID;     w.gated = 1'b1; w.act.capture = 1'b1;
			end
			S_MAC: begin
				w.next_step = S_IDLE;    w.jump_step = S_DIVINIT;
				w.cond = C_LAST;         w.act.mac = 1'b1;
			end
			S_DIVINIT: begin
				w.jump_step = S_DIVSTRT; w.act.div_init = 1'b1;
			end
			S_DIVSTRT: begin
				w.jump_step = S_DIVSTEP; w.act.div_start = 1'b1;
			end
			S_DIVSTEP: begin
				w.next_step = S_DIVSTEP; w.jump_step = S_STORE;
				w.cond = C_DIV_LAST;     w.act.div_step = 1'b1;
			end
			S_STORE: begin
				w.next_step = S_EMIT_RD; w.jump_step = S_DIVSTRT;
				w.cond = C_MORE;         w.act.store = 1'b1;
			end
			S_EMIT_RD: begin
				w.next_step = S_EMIT_RD; w.jump_step = S_EMIT_LD;
				w.cond = C_OUT_FREE;     w.gated = 1'b1; w.act.emit_rd = 1'b1;
			end
			S_EMIT_LD: begin
				w.next_step = S_IDLE;    w.jump_step = S_EMIT_RD;
				w.cond = C_COUNT_NZ;     w.act.emit_ld = 1'b1;
			end
			default: begin
				w.jump_step = S_IDLE;
			end
		endcase
		return w;
	endfunction

	step_t  step_q;
	uword_t uw;
	logic   cond_true;

	assign uw = ucode(step_q);

	always_comb begin
		case (uw.cond)
			C_ALWAYS:   cond_true = 1'b1;
			C_IN_VALID: cond_true = in_valid;
			C_LAST:     cond_true = stat.last;
			C_DIV_LAST: cond_true = stat.div_last;
			C_MORE:     cond_true = stat.more;
			C_OUT_FREE: cond_true = stat.out_free;
			C_COUNT_NZ: cond_true = stat.count_nz;
			default:    cond_true = 1'b0;
		endcase
	end

	assign act      = (uw.gated && !cond_true) ? '0 : uw.act;
	assign in_stall = (step_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= cond_true ? uw.jump_step : uw.next_step;
		end
	end

	a_accept_to_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (step_q == S_MAC))
		else $error("input transfer did not advance to the accumulate step");

	a_mac_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == S_MAC) |=> (step_q == S_IDLE || step_q == S_DIVINIT))
		else $error("accumulate step left to an unexpected step");

	a_one_action_capture: assert property (@(posedge clk) disable iff (!arst_n)
		act.capture |-> (in_valid && step_q == S_IDLE))
		else $error("capture issued without an input transfer");

endmodule

### rtl/core/rc_datapath.sv
// ----------------------------------------------------------------------------
// rc_datapath
// Configuration registers, accumulator, bit-serial divider, digit store and
// output register, all driven by the sequencer's action word.
// ----------------------------------------------------------------------------
module rc_datapath #(
	parameter int ACC_BITS       = rc_pkg::ACC_BITS_DEF,
	parameter int MAX_OUT_DIGITS = rc_pkg::MAX_OUT_DIGITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rc_pkg::REG_W-1:0]     cfg_index,
	input  logic [rc_pkg::BASE_W-1:0]    cfg_data,
	input  logic [rc_pkg::CHAR_W-1:0]    digit_char,
	input  logic                         last_digit,
	input  rc_pkg::act_t                 act,
	output rc_pkg::stat_t                stat,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [rc_pkg::OCHAR_W-1:0]   out_char,
	output logic                         out_last
);
	import rc_pkg::*;

	localparam int CNT_W = $clog2(MAX_OUT_DIGITS + 1);
	localparam int AW    = $clog2(MAX_OUT_DIGITS);
	localparam int BW    = $clog2(ACC_BITS);
	localparam int MW    = ACC_BITS + BASE_W;

	logic [BASE_W-1:0]   source_base_q;
	logic [BASE_W-1:0]   target_base_q;
	logic [BASE_W-1:0]   div_base;
	logic [ACC_BITS-1:0] acc_q;
	logic [ACC_BITS-1:0] dv_q;
	logic [DIGIT_W-1:0]  rem_q;
	logic [DIGIT_W-1:0]  digit_q;
	logic                last_q;
	logic [BW-1:0]       bitcnt_q;
	logic [CNT_W-1:0]    count_q;
	logic [MW-1:0]       mac_full;
	logic [DIGIT_W:0]    trial;
	logic                ge;
	logic [DIGIT_W-1:0]  rdata;
	logic                out_valid_q;
	logic [OCHAR_W-1:0]  out_char_q;
	logic                out_last_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_base_q <= BASE_RESET;
			target_base_q <= BASE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE_BASE: source_base_q <= cfg_data;
				REG_TARGET_BASE: target_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the divisor to the supported radix range
	always_comb begin
		if (target_base_q < BASE_MIN) begin
			div_base = BASE_MIN;
		end else if (target_base_q > BASE_MAX) begin
			div_base = BASE_MAX;
		end else begin
			div_base = target_base_q;
		end
	end

	assign mac_full = MW'(acc_q) * MW'(source_base_q) + MW'(digit_q);

	// Restoring step: shift the next dividend bit into the remainder
	assign trial = {rem_q, dv_q[ACC_BITS-1]};
	assign ge    = (trial >= {1'b0, div_base});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			count_q <= '0;
		end else begin
			if (act.mac) begin
				acc_q <= mac_full[ACC_BITS-1:0];
			end else if (act.div_init) begin
				acc_q <= '0;
			end
			if (act.div_init) begin
				count_q <= '0;
			end else if (act.store) begin
				count_q <= count_q + CNT_W'(1);
			end else if (act.emit_rd) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act.capture) begin
			digit_q <= char_value(digit_char);
			last_q  <= last_digit;
		end
		if (act.div_init) begin
			dv_q <= acc_q;
		end else if (act.div_step) begin
			dv_q <= {dv_q[ACC_BITS-2:0], ge};
		end
		if (act.div_start) begin
			rem_q    <= '0;
			bitcnt_q <= BW'(ACC_BITS - 1);
		end else if (act.div_step) begin
			rem_q    <= ge ? DIGIT_W'(trial - {1'b0, div_base}) : trial[DIGIT_W-1:0];
			bitcnt_q <= bitcnt_q - BW'(1);
		end
	end

	rc_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(MAX_OUT_DIGITS)
	) u_digit_store (
		.clk  (clk),
		.we   (act.store),
		.waddr(count_q[AW-1:0]),
		.wdata(rem_q),
		.re   (act.emit_rd),
		.raddr(AW'(count_q - CNT_W'(1))),
		.rdata(rdata)
	);

	// Output register: load only when empty, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (act.emit_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (act.emit_ld) begin
			out_char_q <= digit_ascii(rdata);
			out_last_q <= (count_q == '0);
		end
	end

	assign stat.last     = last_q;
	assign stat.div_last = (bitcnt_q == '0);
	assign stat.more     = (dv_q != '0) && ((count_q + CNT_W'(1)) != CNT_W'(MAX_OUT_DIGITS));
	assign stat.out_free = !out_valid_q || !out_stall;
	assign stat.count_nz = (count_q != '0);

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_OUT_DIGITS))
		else $error("digit count beyond store depth");

	a_load_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		act.emit_ld |-> !out_valid_q)
		else $error("output register overwritten before transfer");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_char_q >= OCH_0 && out_char_q <= OCH_9) ||
			(out_char_q >= OCH_UA && out_char_q <= OCH_UZ)))
		else $error("output character outside the digit set");

endmodule

### rtl/core/radix_converter.sv
// ----------------------------------------------------------------------------
// radix_converter
// Converts an ASCII number from one radix (2..36) to another.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one source character per transfer,
// most significant first; last_digit marks the final character. Letters of
// either case count 10..35, other non-digit characters count as 0.
// Each non-final character is accepted, then multiply-added; in_stall stays
// high until the multiply-add is done. After the final character the value
// is divided by the target radix one quotient bit per cycle; the remainders
// fill the digit store and are then read back while the receiver keeps up.
// Output channel (out_valid / out_stall): one ASCII digit per transfer, most
// significant first, out_last on the final digit; a zero value gives '0'.
// A stalled output holds in the output register; the block waits on it and
// then continues. The next input is taken while the last digit still waits.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): always ready;
// index 0 is the source radix, index 1 the target radix, both reset to 10.
// Reset clears the accumulator and returns the sequencer to idle; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module radix_converter #(
	parameter int ACC_BITS       = rc_pkg::ACC_BITS_DEF,
	parameter int MAX_OUT_DIGITS = rc_pkg::MAX_OUT_DIGITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [rc_pkg::REG_W-1:0]   cfg_index,
	input  logic [rc_pkg::BASE_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [rc_pkg::CHAR_W-1:0]  digit_char,
	input  logic                       last_digit,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [rc_pkg::OCHAR_W-1:0] out_char,
	output logic                       out_last
);
	import rc_pkg::*;

	act_t  act;
	stat_t stat;

	assign cfg_ready = 1'b1;

	rc_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.act     (act)
	);

	rc_datapath #(
		.ACC_BITS      (ACC_BITS),
		.MAX_OUT_DIGITS(MAX_OUT_DIGITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.digit_char(digit_char),
		.last_digit(last_digit),
		.act       (act),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.out_last  (out_last)
	);

endmodule
